// ----- rtl/core/btpc_pkg.sv -----
package btpc_pkg;

    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned NUM_REGS  = 8;
    localparam int unsigned FRONT_ST  = 11;
    localparam int unsigned DIV_W     = 32;
    localparam int unsigned POST_ST   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_T1    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_T2    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_T3    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_P1    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_P2_P3 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_P4_P5 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_P6_P7 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_P8_P9 = 4'd7;

    localparam logic [31:0] PRESS_OFS  = 32'd64000;
    localparam logic [31:0] PRESS_FULL = 32'd1048576;
    localparam logic [31:0] PRESS_MUL  = 32'd3125;
    localparam logic [31:0] HALF_RANGE = 32'h8000_0000;
    localparam logic [31:0] DIV_BIAS   = 32'd32768;
    localparam logic [31:0] ROUND_T    = 32'd128;

    // Trim words, already widened to 32-bit two's complement patterns.
    typedef struct packed {
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] t3;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] p3;
        logic [31:0] p4;
        logic [31:0] p5;
        logic [31:0] p6;
        logic [31:0] p7;
        logic [31:0] p8;
        logic [31:0] p9;
    } t_trim;

    // Fields that ride alongside the divider.
    typedef struct packed {
        logic [31:0] temp;
        logic        invalid;
        logic        dbl;
    } t_side;

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

endpackage

// ----- rtl/core/btpc_if.sv -----
interface btpc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface btpc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] temperature_centi;
    logic [31:0] pressure_pa;
    logic        pressure_invalid;
    modport source (output valid, output temperature_centi, output pressure_pa,
                    output pressure_invalid, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_pa,
                    input pressure_invalid, output ready);
endinterface

interface btpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/btpc_front.sv -----
module btpc_front
    import btpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [19:0] i_adc_p,
    input  logic [19:0] i_adc_t,
    input  t_trim       i_trim,
    output logic        o_valid,
    output logic [31:0] o_num,
    output logic [31:0] o_div,
    output t_side       o_side
);

    logic [FRONT_ST-1:0] r_v;

    logic [31:0] r_s1_x, r_s1_d, r_s1_p;
    logic [31:0] r_s2_m, r_s2_dd, r_s2_p;
    logic [31:0] r_s3_a, r_s3_e, r_s3_p;
    logic [31:0] r_s4_fine, r_s4_p;
    logic [31:0] r_s5_f5, r_s5_pa, r_s5_p;
    logic [31:0] r_s6_temp, r_s6_qq, r_s6_ap5, r_s6_p2a, r_s6_p;
    logic [31:0] r_s7_temp, r_s7_b1, r_s7_c1, r_s7_ap5, r_s7_p2a, r_s7_p;
    logic [31:0] r_s8_temp, r_s8_b, r_s8_a, r_s8_p;
    logic [31:0] r_s9_temp, r_s9_m, r_s9_pr;
    logic [31:0] r_s10_temp, r_s10_div, r_s10_pr;
    logic [31:0] r_s11_num, r_s11_div;
    t_side       r_s11_side;

    logic [31:0] n_q;
    assign n_q = asr(r_s5_pa, 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[FRONT_ST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_x <= {15'd0, i_adc_t[19:3]} - {i_trim.t1[30:0], 1'b0};
            r_s1_d <= {16'd0, i_adc_t[19:4]} - i_trim.t1;
            r_s1_p <= {12'd0, i_adc_p};

            r_s2_m  <= 32'(r_s1_x * i_trim.t2);
            r_s2_dd <= 32'(r_s1_d * r_s1_d);
            r_s2_p  <= r_s1_p;

            r_s3_a <= asr(r_s2_m, 11);
            r_s3_e <= 32'(asr(r_s2_dd, 12) * i_trim.t3);
            r_s3_p <= r_s2_p;

            r_s4_fine <= r_s3_a + asr(r_s3_e, 14);
            r_s4_p    <= r_s3_p;

            r_s5_f5 <= 32'(r_s4_fine * 32'd5);
            r_s5_pa <= asr(r_s4_fine, 1) - PRESS_OFS;
            r_s5_p  <= r_s4_p;

            r_s6_temp <= asr(r_s5_f5 + ROUND_T, 8);
            r_s6_qq   <= 32'(n_q * n_q);
            r_s6_ap5  <= 32'(r_s5_pa * i_trim.p5);
            r_s6_p2a  <= 32'(i_trim.p2 * r_s5_pa);
            r_s6_p    <= r_s5_p;

            r_s7_temp <= r_s6_temp;
            r_s7_b1   <= 32'(asr(r_s6_qq, 11) * i_trim.p6);
            r_s7_c1   <= 32'(i_trim.p3 * asr(r_s6_qq, 13));
            r_s7_ap5  <= r_s6_ap5;
            r_s7_p2a  <= r_s6_p2a;
            r_s7_p    <= r_s6_p;

            r_s8_temp <= r_s7_temp;
            r_s8_b    <= asr(r_s7_b1 + {r_s7_ap5[30:0], 1'b0}, 2)
                         + {i_trim.p4[15:0], 16'd0};
            r_s8_a    <= asr(asr(r_s7_c1, 3) + asr(r_s7_p2a, 1), 18);
            r_s8_p    <= r_s7_p;

            r_s9_temp <= r_s8_temp;
            r_s9_m    <= 32'((DIV_BIAS + r_s8_a) * i_trim.p1);
            r_s9_pr   <= (PRESS_FULL - r_s8_p) - asr(r_s8_b, 12);

            r_s10_temp <= r_s9_temp;
            r_s10_div  <= asr(r_s9_m, 15);
            r_s10_pr   <= 32'(r_s9_pr * PRESS_MUL);

            // Below half range the numerator is doubled before the divide;
            // otherwise the quotient is doubled afterwards.
            r_s11_num          <= (r_s10_pr < HALF_RANGE) ? {r_s10_pr[30:0], 1'b0}
                                                          : r_s10_pr;
            r_s11_div          <= r_s10_div;
            r_s11_side.temp    <= r_s10_temp;
            r_s11_side.invalid <= (r_s10_div == 32'd0);
            r_s11_side.dbl     <= !(r_s10_pr < HALF_RANGE);
        end
    end

    assign o_valid = r_v[FRONT_ST-1];
    assign o_num   = r_s11_num;
    assign o_div   = r_s11_div;
    assign o_side  = r_s11_side;

endmodule

// ----- rtl/core/btpc_div.sv -----
module btpc_div
    import btpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_num,
    input  logic [31:0] i_div,
    input  t_side       i_side,
    output logic        o_valid,
    output logic [31:0] o_quot,
    output t_side       o_side
);

    // One quotient bit per stage, restoring division.
    logic [DIV_W-1:0] r_v;
    logic [31:0]      r_rem  [DIV_W];
    logic [31:0]      r_nq   [DIV_W];
    logic [31:0]      r_dv   [DIV_W];
    t_side            r_side [DIV_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[DIV_W-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        logic [31:0] n_rem_in, n_nq_in, n_dv_in;
        t_side       n_side_in;
        logic [32:0] n_trial;
        logic        n_ge;

        if (k == 0) begin : g_first
            assign n_rem_in  = 32'd0;
            assign n_nq_in   = i_num;
            assign n_dv_in   = i_div;
            assign n_side_in = i_side;
        end else begin : g_rest
            assign n_rem_in  = r_rem[k-1];
            assign n_nq_in   = r_nq[k-1];
            assign n_dv_in   = r_dv[k-1];
            assign n_side_in = r_side[k-1];
        end

        assign n_trial = {n_rem_in, n_nq_in[31]};
        assign n_ge    = (n_trial >= {1'b0, n_dv_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_ge ? 32'(n_trial - {1'b0, n_dv_in}) : n_trial[31:0];
                r_nq[k]   <= {n_nq_in[30:0], n_ge};
                r_dv[k]   <= n_dv_in;
                r_side[k] <= n_side_in;
            end
        end
    end

    assign o_valid = r_v[DIV_W-1];
    assign o_quot  = r_nq[DIV_W-1];
    assign o_side  = r_side[DIV_W-1];

endmodule

// ----- rtl/core/btpc_post.sv -----
module btpc_post
    import btpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_quot,
    input  t_side       i_side,
    input  t_trim       i_trim,
    output logic        o_valid,
    output logic [31:0] o_temp,
    output logic [31:0] o_press,
    output logic        o_invalid
);

    logic [POST_ST-1:0] r_v;
    logic [31:0] r_s1_p, r_s2_p, r_s3_p;
    logic [31:0] r_s2_sq, r_s2_m8, r_s3_a, r_s3_b;
    logic [31:0] r_s1_temp, r_s2_temp, r_s3_temp, r_s4_temp;
    logic        r_s1_inv, r_s2_inv, r_s3_inv, r_s4_inv;
    logic [31:0] r_s4_press;
    logic [31:0] n_p3;

    assign n_p3 = {3'd0, r_s1_p[31:3]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[POST_ST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_p    <= i_side.dbl ? {i_quot[30:0], 1'b0} : i_quot;
            r_s1_temp <= i_side.temp;
            r_s1_inv  <= i_side.invalid;

            r_s2_sq   <= 32'(n_p3 * n_p3);
            r_s2_m8   <= 32'({2'd0, r_s1_p[31:2]} * i_trim.p8);
            r_s2_p    <= r_s1_p;
            r_s2_temp <= r_s1_temp;
            r_s2_inv  <= r_s1_inv;

            r_s3_a    <= 32'(i_trim.p9 * {13'd0, r_s2_sq[31:13]});
            r_s3_b    <= asr(r_s2_m8, 13);
            r_s3_p    <= r_s2_p;
            r_s3_temp <= r_s2_temp;
            r_s3_inv  <= r_s2_inv;

            // A zero divisor forces the pressure to zero.
            r_s4_press <= r_s3_inv ? 32'd0
                          : r_s3_p + asr(asr(r_s3_a, 12) + r_s3_b + i_trim.p7, 4);
            r_s4_temp  <= r_s3_temp;
            r_s4_inv   <= r_s3_inv;
        end
    end

    assign o_valid   = r_v[POST_ST-1];
    assign o_temp    = r_s4_temp;
    assign o_press   = r_s4_press;
    assign o_invalid = r_s4_inv;

endmodule

// ----- rtl/core/baro_temp_pressure_compensation.sv -----
// Barometric temperature and pressure compensation. Each input beat carries
// one raw 20-bit pressure and one raw 20-bit temperature reading; each output
// beat carries the temperature in hundredths of a degree Celsius, the pressure
// in pascals and a flag that is set, with the pressure forced to zero, when
// the pressure divisor works out to zero. The block is a pipeline that takes
// one beat every cycle unless the output stalls; it has 11 stages of trim
// arithmetic, 32 stages of the radix-2 divider (one quotient bit per stage),
// and 4 stages of final correction, the last of which is the output register.
// A stall on the output freezes the whole pipeline, so nothing is lost or
// repeated. The twelve trim words are written through the configuration
// channel, which is always ready, at indexes 0 to 7; writes to other indexes
// are dropped. All trims reset to zero and must be written only while no beat
// is in flight.
module baro_temp_pressure_compensation
    import btpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    btpc_in_if.sink    i_in,
    btpc_cfg_if.sink   i_cfg,
    btpc_out_if.source o_out
);

    logic [31:0] r_reg [NUM_REGS];
    t_trim       n_trim;
    logic        n_en;

    logic        n_f_v, n_d_v, n_p_v;
    logic [31:0] n_f_num, n_f_div, n_d_quot;
    t_side       n_f_side, n_d_side;

    // Configuration registers, narrow ones masked to 16 bits.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_reg[i] <= '0;
            end
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_T1:    r_reg[0] <= {16'd0, i_cfg.data[15:0]};
                REG_T2:    r_reg[1] <= {16'd0, i_cfg.data[15:0]};
                REG_T3:    r_reg[2] <= {16'd0, i_cfg.data[15:0]};
                REG_P1:    r_reg[3] <= {16'd0, i_cfg.data[15:0]};
                REG_P2_P3: r_reg[4] <= i_cfg.data;
                REG_P4_P5: r_reg[5] <= i_cfg.data;
                REG_P6_P7: r_reg[6] <= i_cfg.data;
                REG_P8_P9: r_reg[7] <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_trim.t1 = r_reg[0];
        n_trim.t2 = sx16(r_reg[1][15:0]);
        n_trim.t3 = sx16(r_reg[2][15:0]);
        n_trim.p1 = r_reg[3];
        n_trim.p2 = sx16(r_reg[4][15:0]);
        n_trim.p3 = sx16(r_reg[4][31:16]);
        n_trim.p4 = sx16(r_reg[5][15:0]);
        n_trim.p5 = sx16(r_reg[5][31:16]);
        n_trim.p6 = sx16(r_reg[6][15:0]);
        n_trim.p7 = sx16(r_reg[6][31:16]);
        n_trim.p8 = sx16(r_reg[7][15:0]);
        n_trim.p9 = sx16(r_reg[7][31:16]);
    end

    // The whole pipeline advances unless a finished result is held by the sink.
    assign n_en       = !n_p_v || o_out.ready;
    assign i_in.ready = n_en;
    assign o_out.valid = n_p_v;

    btpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (i_in.valid),
        .i_adc_p (i_in.raw_pressure),
        .i_adc_t (i_in.raw_temperature),
        .i_trim  (n_trim),
        .o_valid (n_f_v),
        .o_num   (n_f_num),
        .o_div   (n_f_div),
        .o_side  (n_f_side)
    );

    btpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (n_f_v),
        .i_num   (n_f_num),
        .i_div   (n_f_div),
        .i_side  (n_f_side),
        .o_valid (n_d_v),
        .o_quot  (n_d_quot),
        .o_side  (n_d_side)
    );

    btpc_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (n_en),
        .i_valid   (n_d_v),
        .i_quot    (n_d_quot),
        .i_side    (n_d_side),
        .i_trim    (n_trim),
        .o_valid   (n_p_v),
        .o_temp    (o_out.temperature_centi),
        .o_press   (o_out.pressure_pa),
        .o_invalid (o_out.pressure_invalid)
    );

endmodule
